@@ hdl/htfc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the crc-8 helper for the frame checker
package htfc_pkg;

  // crc-8 parameters of the sensor link
  localparam logic [7:0] CRC_TAPS = 8'h31;
  localparam logic [7:0] CRC_SEED = 8'hFF;

  // byte positions inside the six-byte frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // conversion scale factors
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] HUM_SCALE   = 15'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [16:0] TEMP_DIV    = 17'd65534;
  localparam logic [16:0] HUM_DIV     = 17'd65535;

  typedef enum logic {
    JOB_TEMP = 1'b0,
    JOB_HUM  = 1'b1
  } job_kind_t;

  // one checked word handed from the front to the back
  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] raw;
    logic        ok;
  } job_t;

  // one crc-8 byte update, msb first, no reflection
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_TAPS;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

@@ hdl/humidity_temp_frame_checker_top.sv @@
`timescale 1ns / 1ps
// Humidity/temperature readout frame checker. Takes the six sensor bytes
// (temperature MSB, LSB, CRC, humidity MSB, LSB, CRC) one per request, checks
// each word with CRC-8 (poly 0x31, seed 0xFF) and after the sixth byte gives
// one result: last good temperature in 0.01 degC, last good humidity in
// 0.01 %RH, the two CRC flags and an error status. A word that fails its CRC
// leaves the held value unchanged. frame_start restarts the byte count. The
// input takes one byte every cycle while in_stall is low; a result passes
// through the job queue, the multiplier register and the result register,
// with the scaling combinational in between. in_stall rises only when the
// QUEUE_DEPTH-entry job queue fills because out_stall holds back the result.
module humidity_temp_frame_checker_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic               temp_crc_ok,
  output logic               hum_crc_ok,
  output logic               status
);
  import htfc_pkg::*;

  logic accept;
  logic push;
  job_t push_job;
  logic pop;
  logic full;
  logic not_empty;
  job_t head_job;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // byte front end
  htfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .push        (push),
    .push_job    (push_job)
  );

  // job queue
  htfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head_job  (head_job)
  );

  // conversion back end
  htfc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .job_valid         (not_empty),
    .job               (head_job),
    .job_pop           (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .temp_crc_ok       (temp_crc_ok),
    .hum_crc_ok        (hum_crc_ok),
    .status            (status)
  );

endmodule

@@ hdl/htfc_front.sv @@
`timescale 1ns / 1ps
// front end: byte counting, word assembly and crc check
module htfc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  input  logic           frame_start,
  output logic           push,
  output htfc_pkg::job_t push_job
);
  import htfc_pkg::*;

  logic [2:0]  byte_index;
  logic [7:0]  crc_accum;
  logic [15:0] raw_word;
  logic [2:0]  idx;
  logic [7:0]  crc_in;

  // effective position and crc seed for this byte
  always_comb begin
    idx    = frame_start ? POS_T_MSB : byte_index;
    crc_in = frame_start ? CRC_SEED : crc_accum;
    if (idx > POS_H_CRC) begin
      idx    = POS_T_MSB;
      crc_in = CRC_SEED;
    end
  end

  // hand a checked word to the queue on a crc byte
  always_comb begin
    push          = accept && (idx == POS_T_CRC || idx == POS_H_CRC);
    push_job.kind = (idx == POS_H_CRC) ? JOB_HUM : JOB_TEMP;
    push_job.raw  = raw_word;
    push_job.ok   = (crc_in == rx_byte);
  end

  // byte counter and crc accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= POS_T_MSB;
      crc_accum  <= CRC_SEED;
      raw_word   <= 16'h0000;
    end else if (accept) begin
      unique case (idx)
        POS_T_MSB, POS_H_MSB: begin
          crc_accum  <= crc8_step(crc_in, rx_byte);
          raw_word   <= {rx_byte, 8'h00};
          byte_index <= idx + 3'd1;
        end
        POS_T_LSB, POS_H_LSB: begin
          crc_accum  <= crc8_step(crc_in, rx_byte);
          raw_word   <= {raw_word[15:8], rx_byte};
          byte_index <= idx + 3'd1;
        end
        POS_T_CRC: begin
          crc_accum  <= CRC_SEED;
          byte_index <= POS_H_MSB;
        end
        default: begin
          crc_accum  <= CRC_SEED;
          byte_index <= POS_T_MSB;
        end
      endcase
    end
  end

endmodule

@@ hdl/htfc_queue.sv @@
`timescale 1ns / 1ps
// small job queue between the front and back ends
module htfc_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  htfc_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output htfc_pkg::job_t head_job
);
  import htfc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign head_job  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ hdl/htfc_back.sv @@
`timescale 1ns / 1ps
// back end: scaling, held values and the result register
module htfc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  htfc_pkg::job_t      job,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [14:0]  temperature_centi,
  output logic [13:0]         humidity_centi,
  output logic                temp_crc_ok,
  output logic                hum_crc_ok,
  output logic                status
);
  import htfc_pkg::*;

  logic              adv;
  logic              a_valid;
  job_kind_t         a_kind;
  logic              a_ok;
  logic [30:0]       a_prod;
  logic [14:0]       scale;
  logic [14:0]       q0;
  logic [15:0]       lo;
  logic [16:0]       t_rem;
  logic [16:0]       h_rem;
  logic [14:0]       t_val;
  logic [13:0]       h_val;
  logic [14:0]       held_temperature;
  logic [13:0]       held_humidity;
  logic              temp_good;
  logic [13:0]       hum_next;

  assign adv     = !out_valid || !out_stall;
  assign job_pop = adv && job_valid;
  assign scale   = (job.kind == JOB_TEMP) ? TEMP_SCALE : HUM_SCALE;

  // stage one: shared multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind <= job.kind;
      a_ok   <= job.ok;
      a_prod <= 31'(job.raw) * 31'(scale);
    end
  end

  // divide by 2^16-2 or 2^16-1: shift plus one correction step
  always_comb begin
    q0    = a_prod[30:16];
    lo    = a_prod[15:0];
    t_rem = {1'b0, lo} + {1'b0, q0, 1'b0};
    h_rem = {1'b0, lo} + {2'b00, q0};
    t_val = q0 + 15'((t_rem >= TEMP_DIV) ? 1 : 0) - TEMP_OFFSET;
    h_val = 14'(q0 + 15'((h_rem >= HUM_DIV) ? 1 : 0));
    hum_next = a_ok ? h_val : held_humidity;
  end

  // held values
  always_ff @(posedge clk) begin
    if (rst) begin
      held_temperature <= '0;
      held_humidity    <= '0;
      temp_good        <= 1'b0;
    end else if (adv && a_valid) begin
      if (a_kind == JOB_TEMP) begin
        temp_good <= a_ok;
        if (a_ok) begin
          held_temperature <= t_val;
        end
      end else begin
        held_humidity <= hum_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= a_valid && (a_kind == JOB_HUM);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid && a_kind == JOB_HUM) begin
      temperature_centi <= held_temperature;
      humidity_centi    <= hum_next;
      temp_crc_ok       <= temp_good;
      hum_crc_ok        <= a_ok;
      status            <= !(temp_good && a_ok);
    end
  end

endmodule
